FILE: sv/acmm_pkg.sv
package acmm_pkg;

	// lane count of the ports; CHANNEL_COUNT enables the low lanes of these
	localparam int MAX_LANES = 8;
	localparam int LANE_BITS = $clog2(MAX_LANES);
	localparam int COUNT_W = $clog2(MAX_LANES + 1);
	localparam int ACTIVE_W = 4;
	localparam int ROUTE_W = MAX_LANES * MAX_LANES;

	// defaults for the top level parameters
	localparam int DEF_CHANNEL_COUNT = 8;
	localparam int DEF_SAMPLE_BITS = 16;

	// Q1.16 gain arithmetic
	localparam int FRAC_BITS = 16;
	localparam int RECIP_W = FRAC_BITS + 1;
	localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

	// rounded 1/n in Q1.16, indexed by the input count; zero count gives zero
	localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
		17'd0, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10923,
		17'd9362, 17'd8192, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
	};

	// register indexes of the configuration channel
	localparam int CFG_INDEX_W = 2;
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ROUTING    = 2'd0,
		CFG_DIV_GAIN   = 2'd1,
		CFG_MIN_OUTPUT = 2'd2
	} cfg_index_t;

	localparam logic [ROUTE_W-1:0] ROUTING_RESET = 64'h8040_2010_0804_0201;
	localparam logic [ACTIVE_W-1:0] MIN_OUTPUT_RESET = 4'd2;

endpackage

FILE: sv/acmm_lane.sv
// One output lane: select and sum, optional gain multiply, round and saturate.
module acmm_lane #(
	parameter int SAMPLE_BITS = acmm_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic [acmm_pkg::MAX_LANES-1:0]        sel_s1,
	input  logic signed [SAMPLE_BITS-1:0]         smp_s1 [acmm_pkg::MAX_LANES],
	input  logic                                  gain_en,
	output logic                                  used_s2,
	output logic signed [SAMPLE_BITS-1:0]         out_s4
);
	import acmm_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + LANE_BITS;
	localparam int PROD_W = SUM_W + RECIP_W + 1;
	localparam int RND_W = PROD_W - FRAC_BITS;
	localparam logic signed [RND_W-1:0] SAT_HI =
		RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RND_W-1:0] SAT_LO =
		RND_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	logic signed [SUM_W-1:0]  term_c [MAX_LANES];
	logic signed [SUM_W-1:0]  pair_c [MAX_LANES/2];
	logic signed [SUM_W-1:0]  quad_c [MAX_LANES/4];
	logic signed [SUM_W-1:0]  sum_c;
	logic [COUNT_W-1:0]       cnt_c;
	logic signed [SUM_W-1:0]  sum_s2;
	logic [COUNT_W-1:0]       cnt_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic                     gain_s3;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [RND_W-1:0]  mix_val;
	logic signed [RND_W-1:0]  sat_val;

	// stage 2: sum and count of the selected inputs, summed as a balanced tree
	always_comb begin
		for (int i = 0; i < MAX_LANES; i++)
			term_c[i] = sel_s1[i] ? SUM_W'(smp_s1[i]) : '0;
		for (int i = 0; i < MAX_LANES / 2; i++)
			pair_c[i] = term_c[2*i] + term_c[2*i+1];
		for (int i = 0; i < MAX_LANES / 4; i++)
			quad_c[i] = pair_c[2*i] + pair_c[2*i+1];
		sum_c = quad_c[0] + quad_c[1];
		cnt_c = '0;
		for (int i = 0; i < MAX_LANES; i++) begin
			if (sel_s1[i])
				cnt_c = cnt_c + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		sum_s2  <= sum_c;
		cnt_s2  <= cnt_c;
		used_s2 <= (cnt_c != '0);
	end

	// stage 3: multiply by the rounded reciprocal of the count
	always_ff @(posedge clk) begin
		prod_s3 <= sum_s2 * $signed({1'b0, RECIP_TABLE[cnt_s2]});
		sum_s3  <= sum_s2;
		gain_s3 <= gain_en;
	end

	// stage 4: round half up, pick path, saturate
	always_comb begin
		prod_rnd = prod_s3 + PROD_W'(ROUND_HALF);
		mix_val  = gain_s3 ? prod_rnd[PROD_W-1:FRAC_BITS] : RND_W'(sum_s3);
		if (mix_val > SAT_HI)
			sat_val = SAT_HI;
		else if (mix_val < SAT_LO)
			sat_val = SAT_LO;
		else
			sat_val = mix_val;
	end

	always_ff @(posedge clk) begin
		out_s4 <= sat_val[SAMPLE_BITS-1:0];
	end

endmodule

FILE: sv/audio_channel_matrix_mixer.sv
// Channel      Handshake                     Payload
// frame in     start, busy (busy stays low)  input_present, in_sample_0..7
// frame out    done, one cycle strobe        active_outputs, out_sample_0..7
// config       cfg_valid, cfg_ready          cfg_index, cfg_data
//
// One frame per clock; each result shows done after it passes through the pipeline,
// which has four register stages: input, sum, gain multiply, round/saturate.
// arst_n clears the valid chain and loads the register reset values.
// Nothing stalls: the receiver takes every done beat, so busy and
// cfg_ready are constant.
module audio_channel_matrix_mixer #(
	parameter int CHANNEL_COUNT = acmm_pkg::DEF_CHANNEL_COUNT,
	parameter int SAMPLE_BITS   = acmm_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [acmm_pkg::MAX_LANES-1:0]       input_present,
	input  logic signed [SAMPLE_BITS-1:0]        in_sample_0,
	input  logic signed [SAMPLE_BITS-1:0]        in_sample_1,
	input  logic signed [SAMPLE_BITS-1:0]        in_sample_2,
	input  logic signed [SAMPLE_BITS-1:0]        in_sample_3,
	input  logic signed [SAMPLE_BITS-1:0]        in_sample_4,
	input  logic signed [SAMPLE_BITS-1:0]        in_sample_5,
	input  logic signed [SAMPLE_BITS-1:0]        in_sample_6,
	input  logic signed [SAMPLE_BITS-1:0]        in_sample_7,
	output logic                                 done,
	output logic [acmm_pkg::ACTIVE_W-1:0]        active_outputs,
	output logic signed [SAMPLE_BITS-1:0]        out_sample_0,
	output logic signed [SAMPLE_BITS-1:0]        out_sample_1,
	output logic signed [SAMPLE_BITS-1:0]        out_sample_2,
	output logic signed [SAMPLE_BITS-1:0]        out_sample_3,
	output logic signed [SAMPLE_BITS-1:0]        out_sample_4,
	output logic signed [SAMPLE_BITS-1:0]        out_sample_5,
	output logic signed [SAMPLE_BITS-1:0]        out_sample_6,
	output logic signed [SAMPLE_BITS-1:0]        out_sample_7,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [acmm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [acmm_pkg::ROUTE_W-1:0]         cfg_data
);
	import acmm_pkg::*;

	localparam logic [MAX_LANES-1:0] CHAN_MASK = MAX_LANES'((1 << CHANNEL_COUNT) - 1);
	localparam logic [ACTIVE_W-1:0] CHAN_MAX = ACTIVE_W'(CHANNEL_COUNT);

	logic [ROUTE_W-1:0]            routing_q;
	logic                          div_gain_q;
	logic [ACTIVE_W-1:0]           min_out_q;

	logic signed [SAMPLE_BITS-1:0] smp_in [MAX_LANES];
	logic signed [SAMPLE_BITS-1:0] smp_s1 [MAX_LANES];
	logic [MAX_LANES-1:0]          sel_s1 [MAX_LANES];
	logic signed [SAMPLE_BITS-1:0] mix_s4 [MAX_LANES];
	logic [MAX_LANES-1:0]          used_s2;

	logic                          valid_s1, valid_s2, valid_s3, valid_s4;
	logic [LANE_BITS-1:0]          highest_c;
	logic [ACTIVE_W-1:0]           min_clamp;
	logic [ACTIVE_W-1:0]           active_c;
	logic [ACTIVE_W-1:0]           active_s3, active_s4;
	logic                          accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	assign smp_in = '{in_sample_0, in_sample_1, in_sample_2, in_sample_3,
	                  in_sample_4, in_sample_5, in_sample_6, in_sample_7};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			routing_q  <= ROUTING_RESET;
			div_gain_q <= 1'b0;
			min_out_q  <= MIN_OUTPUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROUTING:    routing_q  <= cfg_data;
				CFG_DIV_GAIN:   div_gain_q <= cfg_data[0];
				CFG_MIN_OUTPUT: min_out_q  <= cfg_data[ACTIVE_W-1:0];
				default:        ;
			endcase
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 1: capture samples and per-lane selection masks
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_LANES; k++) begin
			smp_s1[k] <= smp_in[k];
			if (k < CHANNEL_COUNT)
				sel_s1[k] <= routing_q[k*MAX_LANES +: MAX_LANES] & input_present & CHAN_MASK;
			else
				sel_s1[k] <= '0;
		end
	end

	// mixing lanes
	for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
		acmm_lane #(
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_lane (
			.clk         (clk),
			.sel_s1      (sel_s1[g]),
			.smp_s1      (smp_s1),
			.gain_en     (div_gain_q),
			.used_s2     (used_s2[g]),
			.out_s4      (mix_s4[g])
		);
	end

	// active output count from the highest used lane, raised to the configured minimum
	always_comb begin
		highest_c = '0;
		for (int k = 0; k < MAX_LANES; k++) begin
			if (used_s2[k])
				highest_c = LANE_BITS'(k);
		end
		min_clamp = (min_out_q > CHAN_MAX) ? CHAN_MAX : min_out_q;
		active_c  = ACTIVE_W'(highest_c) + ACTIVE_W'(1);
		if (active_c < min_clamp)
			active_c = min_clamp;
	end

	always_ff @(posedge clk) begin
		active_s3 <= active_c;
		active_s4 <= active_s3;
	end

	assign done           = valid_s4;
	assign active_outputs = active_s4;
	assign out_sample_0   = mix_s4[0];
	assign out_sample_1   = mix_s4[1];
	assign out_sample_2   = mix_s4[2];
	assign out_sample_3   = mix_s4[3];
	assign out_sample_4   = mix_s4[4];
	assign out_sample_5   = mix_s4[5];
	assign out_sample_6   = mix_s4[6];
	assign out_sample_7   = mix_s4[7];

	// every captured frame reaches the output through the sum, multiply and output registers
	assert property (@(posedge clk) disable iff (!arst_n) valid_s1 |-> ##3 done)
		else $error("frame lost in pipeline");

	// reported count stays within the enabled channels
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (active_outputs >= ACTIVE_W'(1)) && (active_outputs <= CHAN_MAX))
		else $error("active output count out of range");

	// reported count honors the configured lower bound
	assert property (@(posedge clk) disable iff (!arst_n) done |-> active_outputs >= min_clamp)
		else $error("active output count below minimum");

	// lane 0, when it used no input, mixes to zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !used_s2[0]) |-> ##2 (out_sample_0 == '0))
		else $error("unused lane not zero");

endmodule
